// ===== rtl/drs_pkg.sv =====
`default_nettype none
package drs_pkg;

  // Field widths of the request and result items.
  localparam int ID_BITS    = 10;
  localparam int TRACK_BITS = 16;

  // Policy codes of the policy register; unused codes act as FIFO.
  localparam logic [2:0] POL_FIFO  = 3'd0;
  localparam logic [2:0] POL_SSTF  = 3'd1;
  localparam logic [2:0] POL_LOOK  = 3'd2;
  localparam logic [2:0] POL_CLOOK = 3'd3;
  localparam logic [2:0] POL_FSCAN = 3'd4;

  typedef struct packed {
    logic                  req_type;
    logic [ID_BITS-1:0]    req_id;
    logic [TRACK_BITS-1:0] req_track;
    logic [TRACK_BITS-1:0] head_track;
    logic                  head_down;
  } req_t;

  typedef struct packed {
    logic                  accepted;
    logic                  found;
    logic [ID_BITS-1:0]    grant_id;
    logic [TRACK_BITS-1:0] grant_track;
    logic                  head_down_after;
  } res_t;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_SELECT = 1'b1
  } op_t;

  // Classified command passed from the front queue to the engine.
  typedef struct packed {
    op_t                   op;
    logic [ID_BITS-1:0]    id;
    logic [TRACK_BITS-1:0] track;
    logic [TRACK_BITS-1:0] head;
    logic                  down;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_PICK,
    ST_HOLD
  } eng_state_t;

endpackage
`default_nettype wire

// ===== rtl/disk_request_scheduler.sv =====
`default_nettype none
// Disk request scheduler. Requests enter through a two-entry command queue and are
// served one at a time by a scheduling engine. An add runs ADD and HOLD; a select
// scans the request slots one per cycle via the single slot read port, then PICK and
// HOLD. Results wait in a one-entry output register, so the command queue keeps taking
// requests while a result is not yet popped. The user is to write the policy register
// through the configuration channel only while the block is idle; it is not enforced.
module disk_request_scheduler #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire drs_pkg::req_t req,
  output logic               empty,
  input  wire logic          pop,
  output drs_pkg::res_t      res,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_data
);
  import drs_pkg::*;

  logic [2:0] policy;
  logic       cmd_valid;
  logic       cmd_ready;
  cmd_t       cmd;
  logic       eng_valid;
  logic       eng_ready;
  res_t       eng_res;
  logic       out_valid;
  res_t       out_res;

  drs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  drs_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .policy    (policy),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (eng_valid),
    .res_ready (eng_ready),
    .res       (eng_res)
  );

  // Policy register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) policy <= POL_FIFO;
    else if (cfg_valid && cfg_ready) policy <= cfg_data;
  end

  // Output register; a new result may enter in the cycle the old one is popped.
  assign eng_ready = !out_valid || pop;
  assign empty     = !out_valid;
  assign res       = out_res;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (eng_valid && eng_ready) out_valid <= 1'b1;
    else if (pop) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (eng_valid && eng_ready) out_res <= eng_res;
  end

endmodule
`default_nettype wire

// ===== rtl/drs_front.sv =====
`default_nettype none
module drs_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire drs_pkg::req_t req,
  output logic               cmd_valid,
  input  wire logic          cmd_ready,
  output drs_pkg::cmd_t      cmd
);
  import drs_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cmd_in;
  logic       do_push;
  logic       do_pop;

  // Classify the incoming request into a command.
  always_comb begin
    cmd_in.op    = op_t'(req.req_type);
    cmd_in.id    = req.req_id;
    cmd_in.track = req.req_track;
    cmd_in.head  = req.head_track;
    cmd_in.down  = req.head_down;
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_valid && cmd_ready;

  // Pointers and fill level of the two-entry queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= cmd_in;
  end

endmodule
`default_nettype wire

// ===== rtl/drs_engine.sv =====
`default_nettype none
module drs_engine #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [2:0]    policy,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire drs_pkg::cmd_t cmd,
  output logic               res_valid,
  input  wire logic          res_ready,
  output drs_pkg::res_t      res
);
  import drs_pkg::*;

  localparam int IDX_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam int NTRK     = 8;
  localparam int T_AGE    = 0;
  localparam int T_NEAR   = 1;
  localparam int T_DIR    = 2;
  localparam int T_LOW    = 3;
  localparam int T_FDIR0  = 4;
  localparam int T_FDIR1  = 5;
  localparam int T_FNEAR0 = 6;
  localparam int T_FNEAR1 = 7;

  typedef struct packed {
    logic                  hit;
    logic [TRACK_BITS-1:0] key;
    logic [IDX_BITS-1:0]   age;
    logic [IDX_BITS-1:0]   idx;
    logic [ID_BITS-1:0]    id;
    logic [TRACK_BITS-1:0] track;
  } trk_t;

  eng_state_t state, state_next;

  logic                  slot_valid [QUEUE_DEPTH];
  logic [ID_BITS-1:0]    slot_id    [QUEUE_DEPTH];
  logic [TRACK_BITS-1:0] slot_track [QUEUE_DEPTH];
  logic                  slot_set   [QUEUE_DEPTH];
  logic [IDX_BITS-1:0]   slot_age   [QUEUE_DEPTH];
  logic                  active_set;
  logic [CNT_BITS-1:0]   queue_count;

  cmd_t                  cmd_q;
  res_t                  res_q;
  logic [IDX_BITS-1:0]   scan_idx;
  logic                  scan_last;
  trk_t                  trk      [NTRK];
  trk_t                  trk_next [NTRK];

  // Fields of the slot under scan.
  logic                  cur_valid;
  logic [TRACK_BITS-1:0] cur_track;
  logic [IDX_BITS-1:0]   cur_age;
  logic                  cur_set;
  logic [ID_BITS-1:0]    cur_id;
  logic [TRACK_BITS-1:0] cur_dist;
  logic [TRACK_BITS-1:0] age_key;
  logic                  up_ok;
  logic                  dn_ok;
  logic                  dir_any_ok;
  logic                  dir_f_ok;

  // Add and pick decisions.
  logic                  q_full;
  logic [IDX_BITS-1:0]   free_idx;
  trk_t                  win;
  logic                  down_after;
  logic                  set_toggle;
  trk_t                  f_dir;
  trk_t                  f_near;
  logic                  f_set;

  // Replace a tracker when the candidate qualifies and beats it; ties go to the older entry.
  function automatic trk_t upd(trk_t t, logic ok, logic [TRACK_BITS-1:0] key,
                               logic [IDX_BITS-1:0] age, logic [IDX_BITS-1:0] idx,
                               logic [ID_BITS-1:0] id, logic [TRACK_BITS-1:0] track);
    trk_t r;
    r = t;
    if (ok && (!t.hit || key < t.key || (key == t.key && age < t.age))) begin
      r.hit   = 1'b1;
      r.key   = key;
      r.age   = age;
      r.idx   = idx;
      r.id    = id;
      r.track = track;
    end
    return r;
  endfunction

  assign cur_valid  = slot_valid[scan_idx];
  assign cur_track  = slot_track[scan_idx];
  assign cur_age    = slot_age[scan_idx];
  assign cur_set    = slot_set[scan_idx];
  assign cur_id     = slot_id[scan_idx];
  assign up_ok      = (cur_track >= cmd_q.head);
  assign dn_ok      = (cur_track <= cmd_q.head);
  assign cur_dist   = up_ok ? (cur_track - cmd_q.head) : (cmd_q.head - cur_track);
  assign age_key    = TRACK_BITS'(cur_age);
  assign dir_any_ok = (policy == POL_LOOK && cmd_q.down) ? dn_ok : up_ok;
  assign dir_f_ok   = cmd_q.down ? dn_ok : up_ok;
  assign scan_last  = (scan_idx == IDX_BITS'(QUEUE_DEPTH - 1));
  assign q_full     = (queue_count >= CNT_BITS'(QUEUE_DEPTH));

  // Fold the slot under scan into every tracker.
  always_comb begin
    trk_next[T_AGE]    = upd(trk[T_AGE], cur_valid, age_key, cur_age, scan_idx,
                             cur_id, cur_track);
    trk_next[T_NEAR]   = upd(trk[T_NEAR], cur_valid, cur_dist, cur_age, scan_idx,
                             cur_id, cur_track);
    trk_next[T_DIR]    = upd(trk[T_DIR], cur_valid && dir_any_ok, cur_dist, cur_age,
                             scan_idx, cur_id, cur_track);
    trk_next[T_LOW]    = upd(trk[T_LOW], cur_valid, cur_track, cur_age, scan_idx,
                             cur_id, cur_track);
    trk_next[T_FDIR0]  = upd(trk[T_FDIR0], cur_valid && !cur_set && dir_f_ok, cur_dist,
                             cur_age, scan_idx, cur_id, cur_track);
    trk_next[T_FDIR1]  = upd(trk[T_FDIR1], cur_valid && cur_set && dir_f_ok, cur_dist,
                             cur_age, scan_idx, cur_id, cur_track);
    trk_next[T_FNEAR0] = upd(trk[T_FNEAR0], cur_valid && !cur_set, cur_dist, cur_age,
                             scan_idx, cur_id, cur_track);
    trk_next[T_FNEAR1] = upd(trk[T_FNEAR1], cur_valid && cur_set, cur_dist, cur_age,
                             scan_idx, cur_id, cur_track);
  end

  // Lowest free slot for an add.
  always_comb begin
    free_idx = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!slot_valid[i]) free_idx = IDX_BITS'(i);
    end
  end

  // Choose the winner from the trackers by policy.
  always_comb begin
    win        = trk[T_AGE];
    down_after = cmd_q.down;
    set_toggle = 1'b0;
    f_set      = active_set;
    f_dir      = trk[T_FDIR0];
    f_near     = trk[T_FNEAR0];
    unique case (policy)
      POL_SSTF: win = trk[T_NEAR];
      POL_LOOK: win = trk[T_DIR].hit ? trk[T_DIR] : trk[T_NEAR];
      POL_CLOOK: win = trk[T_DIR].hit ? trk[T_DIR] : trk[T_LOW];
      POL_FSCAN: begin
        if (!(active_set ? trk[T_FNEAR1].hit : trk[T_FNEAR0].hit)) begin
          set_toggle = 1'b1;
          f_set      = ~active_set;
        end
        f_dir  = f_set ? trk[T_FDIR1] : trk[T_FDIR0];
        f_near = f_set ? trk[T_FNEAR1] : trk[T_FNEAR0];
        if (f_dir.hit) begin
          win = f_dir;
        end else begin
          win = f_near;
          if (f_near.hit) down_after = ~cmd_q.down;
        end
      end
      default: win = trk[T_AGE];
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (cmd_valid) state_next = (cmd.op == OP_ADD) ? ST_ADD : ST_SCAN;
      ST_ADD:  state_next = ST_HOLD;
      ST_SCAN: if (scan_last) state_next = ST_PICK;
      ST_PICK: state_next = ST_HOLD;
      ST_HOLD: if (res_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    cmd_ready = (state == ST_IDLE);
    res_valid = (state == ST_HOLD);
  end

  assign res = res_q;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Command latch, scan counter, trackers and result.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid) cmd_q <= cmd;
    if (state == ST_IDLE) begin
      scan_idx <= '0;
      for (int k = 0; k < NTRK; k++) trk[k].hit <= 1'b0;
    end else if (state == ST_SCAN) begin
      scan_idx <= scan_idx + IDX_BITS'(1);
      for (int k = 0; k < NTRK; k++) trk[k] <= trk_next[k];
    end
    if (state == ST_ADD) begin
      res_q.accepted        <= !q_full;
      res_q.found           <= 1'b0;
      res_q.grant_id        <= '0;
      res_q.grant_track     <= '0;
      res_q.head_down_after <= 1'b0;
    end else if (state == ST_PICK) begin
      res_q.accepted        <= 1'b1;
      res_q.found           <= win.hit;
      res_q.grant_id        <= win.hit ? win.id : '0;
      res_q.grant_track     <= win.hit ? win.track : '0;
      res_q.head_down_after <= down_after;
    end
  end

  // Queue control state: valid bits, fill count and active set.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) slot_valid[i] <= 1'b0;
      active_set  <= 1'b0;
      queue_count <= '0;
    end else if (state == ST_ADD && !q_full) begin
      slot_valid[free_idx] <= 1'b1;
      queue_count          <= queue_count + CNT_BITS'(1);
    end else if (state == ST_PICK) begin
      if (set_toggle) active_set <= ~active_set;
      if (win.hit) begin
        slot_valid[win.idx] <= 1'b0;
        queue_count         <= queue_count - CNT_BITS'(1);
      end
    end
  end

  // Slot payload and arrival ranks.
  always_ff @(posedge clk) begin
    if (state == ST_ADD && !q_full) begin
      slot_id[free_idx]    <= cmd_q.id;
      slot_track[free_idx] <= cmd_q.track;
      slot_set[free_idx]   <= ~active_set;
      slot_age[free_idx]   <= queue_count[IDX_BITS-1:0];
    end else if (state == ST_PICK && win.hit) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (slot_valid[i] && slot_age[i] > win.age) slot_age[i] <= slot_age[i] - IDX_BITS'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import drs_pkg::*;

  localparam int DEPTH = 16;
  localparam int RANDOM_ITEMS = 1550;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 40;

  // Search kinds of the predictor.
  localparam int KIND_AGE  = 0;
  localparam int KIND_NEAR = 1;
  localparam int KIND_UP   = 2;
  localparam int KIND_DOWN = 3;
  localparam int KIND_LOW  = 4;

  // Scheduler predictor: the slot store, the FSCAN set state and the policy.
  class sched_scoreboard;
    logic [2:0] policy;
    bit slot_used[DEPTH];
    logic [ID_BITS-1:0] slot_ident[DEPTH];
    logic [TRACK_BITS-1:0] slot_trk[DEPTH];
    bit slot_grp[DEPTH];
    int slot_rank[DEPTH];
    bit cur_set;
    int occupancy;
    res_t pending_results[$];
    int mismatches;

    function void clear();
      policy = POL_FIFO;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      cur_set = 1'b0;
      occupancy = 0;
      pending_results.delete();
      mismatches = 0;
    endfunction

    // Kinds: oldest, nearest, nearest at or above, nearest at or below, lowest track.
    function int best_slot(int kind, logic [TRACK_BITS-1:0] head, int grp);
      int best;
      longint key;
      longint best_key;
      best = -1;
      best_key = 0;
      for (int i = 0; i < DEPTH; i++) begin
        if (!slot_used[i]) continue;
        if (grp >= 0 && slot_grp[i] != grp[0]) continue;
        if (kind == KIND_UP && slot_trk[i] < head) continue;
        if (kind == KIND_DOWN && slot_trk[i] > head) continue;
        if (kind == KIND_AGE) key = slot_rank[i];
        else if (kind == KIND_LOW) key = slot_trk[i];
        else key = (slot_trk[i] >= head) ? slot_trk[i] - head : head - slot_trk[i];
        if (best < 0 || key < best_key ||
            (key == best_key && slot_rank[i] < slot_rank[best])) begin
          best = i;
          best_key = key;
        end
      end
      return best;
    endfunction

    // Notes an accepted request and queues the result it must produce.
    function void note_request(req_t r);
      res_t e;
      int s;
      bit dn;
      e = '0;
      s = -1;
      if (r.req_type == OP_ADD) begin
        for (int i = 0; i < DEPTH; i++)
          if (!slot_used[i]) begin
            s = i;
            break;
          end
        if (s >= 0 && occupancy < DEPTH) begin
          slot_used[s] = 1'b1;
          slot_ident[s] = r.req_id;
          slot_trk[s] = r.req_track;
          slot_grp[s] = ~cur_set;
          slot_rank[s] = occupancy;
          occupancy++;
          e.accepted = 1'b1;
        end
        pending_results.insert(pending_results.size(), e);
        return;
      end
      dn = r.head_down;
      e.accepted = 1'b1;
      s = -1;
      case (policy)
        POL_SSTF: s = best_slot(KIND_NEAR, r.head_track, -1);
        POL_LOOK: begin
          s = best_slot(dn ? KIND_DOWN : KIND_UP, r.head_track, -1);
          if (s < 0) s = best_slot(KIND_NEAR, r.head_track, -1);
        end
        POL_CLOOK: begin
          s = best_slot(KIND_UP, r.head_track, -1);
          if (s < 0) s = best_slot(KIND_LOW, r.head_track, -1);
        end
        POL_FSCAN: begin
          if (best_slot(KIND_AGE, r.head_track, cur_set) < 0) cur_set = ~cur_set;
          if (best_slot(KIND_AGE, r.head_track, cur_set) >= 0) begin
            s = best_slot(dn ? KIND_DOWN : KIND_UP, r.head_track, cur_set);
            if (s < 0) begin
              dn = ~dn;
              s = best_slot(KIND_NEAR, r.head_track, cur_set);
            end
          end
        end
        default: s = best_slot(KIND_AGE, r.head_track, -1);
      endcase
      e.head_down_after = dn;
      if (s >= 0) begin
        e.found = 1'b1;
        e.grant_id = slot_ident[s];
        e.grant_track = slot_trk[s];
        slot_used[s] = 1'b0;
        for (int i = 0; i < DEPTH; i++)
          if (slot_used[i] && slot_rank[i] > slot_rank[s]) slot_rank[i]--;
        occupancy--;
      end
      pending_results.insert(pending_results.size(), e);
    endfunction

    // Compares one popped result with the oldest expectation.
    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", got);
        return;
      end
      want = pending_results[0];
      pending_results.delete(0);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("Result mismatch: expected %p, actual %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic full;
  req_t req = '0;
  logic empty;
  logic pop = 0;
  res_t res;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_data = '0;

  sched_scoreboard board = new();
  int cycle_count = 0;
  logic [TRACK_BITS-1:0] track_pool[8];

  always #2 clk = ~clk;

  disk_request_scheduler #(.QUEUE_DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .req(req),
    .empty(empty), .pop(pop), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Cycle limit guards against a hang.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Sends one request and waits for its transfer; push stays high for a following
  // request without a gap.
  task automatic send_request(req_t r);
    int gap;
    gap = $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      push <= 0;
      repeat (gap) @(posedge clk);
    end
    push <= 1;
    req <= r;
    do @(posedge clk); while (full);
    board.note_request(r);
  endtask

  // Drops push after the last transfer.
  task automatic stop_push();
    push <= 0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    stop_push();
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes the policy register while the block is idle.
  task automatic write_policy(logic [2:0] mode);
    wait_drained();
    cfg_valid <= 1;
    cfg_data <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    board.policy = mode;
  endtask

  function automatic req_t add_req(logic [ID_BITS-1:0] id, logic [TRACK_BITS-1:0] trk);
    req_t r;
    r = '0;
    r.req_type = OP_ADD;
    r.req_id = id;
    r.req_track = trk;
    r.head_track = TRACK_BITS'($urandom);
    r.head_down = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic req_t sel_req(logic [TRACK_BITS-1:0] head, logic down);
    req_t r;
    r = '0;
    r.req_type = OP_SELECT;
    r.req_id = ID_BITS'($urandom);
    r.req_track = TRACK_BITS'($urandom);
    r.head_track = head;
    r.head_down = down;
    return r;
  endfunction

  // Tracks come from a small pool often, so ties and equal distances occur.
  function automatic logic [TRACK_BITS-1:0] pick_track();
    if ($urandom_range(0, 1) == 0) return track_pool[$urandom_range(0, 7)];
    return TRACK_BITS'($urandom);
  endfunction

  // Result side: pops with random stalls and checks every transfer.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, 14);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        pop <= 0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1;
      do @(posedge clk); while (empty);
      board.check_result(res);
    end
  end

  // Stimulus.
  initial begin
    int done_items;
    logic [2:0] mode;
    board.clear();
    foreach (track_pool[i]) track_pool[i] = TRACK_BITS'($urandom);
    track_pool[0] = '0;
    track_pool[1] = '1;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part: empty select, extremes, fill past full, FIFO selects.
    send_request(sel_req('0, 1'b0));
    send_request(add_req('1, '1));
    send_request(add_req('0, '0));
    for (int i = 0; i < 16; i++) send_request(add_req(i[9:0] + 10'd5, 16'd100));
    send_request(sel_req('1, 1'b1));
    send_request(sel_req(16'd100, 1'b0));
    for (int i = 0; i < 3; i++)
      send_request(sel_req(TRACK_BITS'($urandom), 1'($urandom_range(0, 1))));

    // Random part: phases across all policy codes, each code in order first, then random codes.
    done_items = 0;
    for (int ph = 0; done_items < RANDOM_ITEMS; ph++) begin
      if (ph < 8) mode = ph[2:0];
      else mode = 3'($urandom_range(0, 7));
      write_policy(mode);
      for (int k = 0; k < 120 && done_items < RANDOM_ITEMS; k++) begin
        if (ph == 2 && k == 60) begin
          stop_push();
          while (board.pending_results.size() != 0) @(posedge clk);
        end
        if ($urandom_range(0, 99) < 55 - (board.occupancy > 12 ? 20 : 0))
          send_request(add_req(ID_BITS'($urandom), pick_track()));
        else
          send_request(sel_req(pick_track(), 1'($urandom_range(0, 1))));
        done_items++;
      end
    end

    wait_drained();
    if (board.mismatches == 0 && board.pending_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
